// ===== design/ekey_pkg.sv =====
// Shared types and constants for the encoder key event block.
package ekey_pkg;

	localparam int KEY_W   = 8;
	localparam int MAX_REL = 16;

	localparam logic [2:0] REG_CCW_KEYS  = 3'd0;
	localparam logic [2:0] REG_CW_KEYS   = 3'd1;
	localparam logic [2:0] REG_BTN_KEYS  = 3'd2;
	localparam logic [2:0] REG_STEP_THR  = 3'd3;
	localparam logic [2:0] REG_BTN_MASK  = 3'd4;
	localparam logic [2:0] REG_HOLD_TIME = 3'd5;
	localparam logic [2:0] REG_DEB_TIME  = 3'd6;

	localparam logic [15:0] HOLD_TIME_RST = 16'd15;
	localparam logic [15:0] DEB_TIME_RST  = 16'd5;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_ms;
		logic [2:0]  encoder_index;
		logic [15:0] counter_value;
		logic        button_level;
	} in_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic             pressed;
		logic             last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic             wr_en;
		logic [KEY_W-1:0] wr_key;
		logic [31:0]      wr_time;
		logic             clr_en;
		logic [KEY_W-1:0] clr_key;
	} tstore_cmd_t;

endpackage

// ===== design/ekey_timer_store.sv =====
// Release-time memory with per-key armed flags.
module ekey_timer_store #(
	parameter int KEYS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ekey_pkg::tstore_cmd_t         cmd,
	input  logic [ekey_pkg::KEY_W-1:0]    rd_addr,
	output logic [31:0]                   rd_time,
	output logic                          rd_armed
);

	localparam int IW = $clog2(KEYS);

	logic [31:0]     mem [KEYS];
	logic [KEYS-1:0] armed_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_key[IW-1:0]] <= cmd.wr_time;
		end
		rd_time <= mem[rd_addr[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= '0;
			rd_armed <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				armed_q[cmd.wr_key[IW-1:0]] <= 1'b1;
			end
			if (cmd.clr_en) begin
				armed_q[cmd.clr_key[IW-1:0]] <= 1'b0;
			end
			rd_armed <= armed_q[rd_addr[IW-1:0]];
		end
	end

endmodule

// ===== design/encoder_key_events.sv =====
// Top level: encoder step keys, button debounce and timed key release.
//
//  channel   direction  handshake            beat
//  in        input      in_valid / in_ready  ekey_pkg::in_beat_t (tick or sample)
//  out       output     out_valid/out_ready  ekey_pkg::out_beat_t (key press/release)
//  cfg       input      cfg_we               cfg_index, cfg_data (write only)
//
// A tick walks the release-time memory one key per cycle through one shared
// 32-bit compare, pausing while a release waits on a full output register;
// it stops early after the sixteenth release.
// A sample is evaluated once, then emits its results (up to two) in turn.
// in_ready is high only while idle; a stalled output holds its beat and the
// block waits with it. Reset clears the armed flags at once, with no clearing pass.
module encoder_key_events #(
	parameter int ENCODERS = 2,
	parameter int KEYS     = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ekey_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ekey_pkg::out_beat_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int IW = $clog2(KEYS);
	localparam int EW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
	localparam logic [IW:0] KEYS_END = (IW+1)'(KEYS);
	localparam logic [ekey_pkg::KEY_W:0] KEYS_LIM = (ekey_pkg::KEY_W+1)'(KEYS);
	localparam logic [3:0] ENC_LIM = 4'(ENCODERS);
	localparam logic [4:0] REL_LAST = 5'(ekey_pkg::MAX_REL - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_SAMPLE,
		ST_EMIT_STEP,
		ST_EMIT_BTN
	} state_t;

	// configuration registers
	logic [63:0] ccw_keys_q, cw_keys_q, btn_keys_q, step_thr_q;
	logic [7:0]  btn_mask_q;
	logic [15:0] hold_time_q, deb_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccw_keys_q  <= '0;
			cw_keys_q   <= '0;
			btn_keys_q  <= '0;
			step_thr_q  <= '0;
			btn_mask_q  <= '0;
			hold_time_q <= ekey_pkg::HOLD_TIME_RST;
			deb_time_q  <= ekey_pkg::DEB_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ekey_pkg::REG_CCW_KEYS:  ccw_keys_q  <= cfg_data;
				ekey_pkg::REG_CW_KEYS:   cw_keys_q   <= cfg_data;
				ekey_pkg::REG_BTN_KEYS:  btn_keys_q  <= cfg_data;
				ekey_pkg::REG_STEP_THR:  step_thr_q  <= cfg_data;
				ekey_pkg::REG_BTN_MASK:  btn_mask_q  <= cfg_data[7:0];
				ekey_pkg::REG_HOLD_TIME: hold_time_q <= cfg_data[15:0];
				ekey_pkg::REG_DEB_TIME:  deb_time_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	state_t                      state_q;
	ekey_pkg::in_beat_t          in_q;
	logic                        out_valid_q;
	ekey_pkg::out_beat_t         out_data_q;

	// scan pipeline: issue address, then compare the registered read
	logic [IW:0]                 issue_idx_q;
	logic [IW-1:0]               idx_s1_q;
	logic                        s1_v_q;
	logic [4:0]                  rel_cnt_q;
	logic                        hold_v_q;
	logic [ekey_pkg::KEY_W-1:0]  hold_key_q;

	// per-encoder state
	logic [15:0]                 last_count_q [ENCODERS];
	logic [31:0]                 last_chg_q   [ENCODERS];
	logic [ENCODERS-1:0]         deb_level_q;

	// sample results waiting to go out
	logic                        step_hit_q, btn_hit_q, btn_press_q;
	logic [ekey_pkg::KEY_W-1:0]  step_key_q, btn_key_q;

	ekey_pkg::tstore_cmd_t       cmd;
	logic [ekey_pkg::KEY_W-1:0]  rd_addr;
	logic [31:0]                 rd_time;
	logic                        rd_armed;

	logic        slot_free, hit, scan_stall;
	logic        enc_ok, step_cw, step_ccw, step_any, btn_present, lvl_diff, deb_ok;
	logic [EW-1:0] ei;
	logic [7:0]  thr, step_key;
	logic [15:0] diff;
	logic [16:0] delta, thr_pos, thr_neg;
	logic [31:0] elapsed;

	always_comb begin
		slot_free  = !out_valid_q || out_ready;
		hit        = s1_v_q && rd_armed && (in_q.now_ms >= rd_time);
		scan_stall = (state_q == ST_SCAN) && hit && hold_v_q && !slot_free;
		// re-read the stalled key so its data stays in the compare stage
		rd_addr    = scan_stall ? ekey_pkg::KEY_W'(idx_s1_q)
		                        : ekey_pkg::KEY_W'(issue_idx_q[IW-1:0]);

		enc_ok      = {1'b0, in_q.encoder_index} < ENC_LIM;
		ei          = in_q.encoder_index[EW-1:0];
		thr         = step_thr_q[in_q.encoder_index*8 +: 8];
		diff        = in_q.counter_value - last_count_q[ei];
		delta       = {diff[15], diff};
		thr_pos     = {9'd0, thr};
		thr_neg     = 17'd0 - thr_pos;
		step_cw     = $signed(delta) >= $signed(thr_pos);
		step_ccw    = $signed(delta) <= $signed(thr_neg);
		step_any    = step_cw || step_ccw;
		step_key    = step_cw ? cw_keys_q[in_q.encoder_index*8 +: 8]
		                      : ccw_keys_q[in_q.encoder_index*8 +: 8];
		btn_present = btn_mask_q[in_q.encoder_index];
		lvl_diff    = in_q.button_level != deb_level_q[ei];
		elapsed     = in_q.now_ms - last_chg_q[ei];
		deb_ok      = elapsed >= {16'd0, deb_time_q};

		cmd.wr_en   = (state_q == ST_SAMPLE) && enc_ok && step_any &&
		              ({1'b0, step_key} < KEYS_LIM);
		cmd.wr_key  = step_key;
		cmd.wr_time = in_q.now_ms + {16'd0, hold_time_q};
		cmd.clr_en  = (state_q == ST_SCAN) && hit && !scan_stall;
		cmd.clr_key = ekey_pkg::KEY_W'(idx_s1_q);
	end

	ekey_timer_store #(
		.KEYS(KEYS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.rd_time (rd_time),
		.rd_armed(rd_armed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			s1_v_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			rel_cnt_q   <= '0;
			issue_idx_q <= '0;
			step_hit_q  <= 1'b0;
			btn_hit_q   <= 1'b0;
			deb_level_q <= '1;
			for (int i = 0; i < ENCODERS; i++) begin
				last_count_q[i] <= '0;
				last_chg_q[i]   <= '0;
			end
		end else begin
			// drop a beat once the sink takes it; a push below overrides
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						in_q        <= in_data;
						issue_idx_q <= '0;
						s1_v_q      <= 1'b0;
						rel_cnt_q   <= '0;
						hold_v_q    <= 1'b0;
						state_q     <= in_data.req_type ? ST_SAMPLE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (hit) begin
							// a newer release proves the held one is not last
							if (hold_v_q) begin
								out_valid_q <= 1'b1;
								out_data_q  <= '{key_code: hold_key_q, pressed: 1'b0,
								                 last_of_run: 1'b0};
							end
							hold_key_q <= ekey_pkg::KEY_W'(idx_s1_q);
							hold_v_q   <= 1'b1;
							rel_cnt_q  <= rel_cnt_q + 5'd1;
						end
						if ((hit && rel_cnt_q == REL_LAST) || issue_idx_q == KEYS_END) begin
							s1_v_q  <= 1'b0;
							state_q <= ST_FINISH;
						end else begin
							idx_s1_q    <= issue_idx_q[IW-1:0];
							s1_v_q      <= 1'b1;
							issue_idx_q <= issue_idx_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= '{key_code: hold_key_q, pressed: 1'b0,
						                 last_of_run: 1'b1};
						hold_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_SAMPLE: begin
					if (enc_ok && step_any) begin
						last_count_q[ei] <= in_q.counter_value;
					end
					if (enc_ok && btn_present) begin
						if (!lvl_diff) begin
							last_chg_q[ei] <= in_q.now_ms;
						end else if (deb_ok) begin
							deb_level_q[ei] <= in_q.button_level;
						end
					end
					step_hit_q  <= enc_ok && step_any;
					btn_hit_q   <= enc_ok && btn_present && lvl_diff && deb_ok;
					step_key_q  <= step_key;
					btn_key_q   <= btn_keys_q[in_q.encoder_index*8 +: 8];
					btn_press_q <= !in_q.button_level;
					priority if (enc_ok && step_any) begin
						state_q <= ST_EMIT_STEP;
					end else if (enc_ok && btn_present && lvl_diff && deb_ok) begin
						state_q <= ST_EMIT_BTN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_STEP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= '{key_code: step_key_q, pressed: 1'b1,
						                 last_of_run: !btn_hit_q};
						state_q     <= btn_hit_q ? ST_EMIT_BTN : ST_IDLE;
					end
				end
				ST_EMIT_BTN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= '{key_code: btn_key_q, pressed: btn_press_q,
						                 last_of_run: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block took a beat while busy");

	a_no_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("held release left behind at end of tick");

	a_release_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rel_cnt_q <= 5'(ekey_pkg::MAX_REL))
		else $error("tick released more keys than allowed");

	a_no_arm_and_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.clr_en))
		else $error("timer store armed and cleared in one cycle");
`endif

endmodule

// ===== verif/ekey_check_pkg.sv =====
// Key event prediction and result checking for the encoder key event bench.
`timescale 1ns / 100ps
package ekey_check_pkg;
	import ekey_pkg::*;

	localparam int N_ENC  = 2;
	localparam int N_KEYS = 256;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// no register sits at this index; writes to it are dropped
	localparam logic [2:0] REG_UNUSED = 3'd7;

	class key_event_tracker;
		logic [63:0] ccw_keys, cw_keys, btn_keys, step_need;
		logic [7:0]  btn_mask;
		logic [15:0] hold_ms, deb_ms;

		bit [31:0] expiry [N_KEYS];
		bit        armed [N_KEYS];
		bit [15:0] synced_count [N_ENC];
		bit        settled_level [N_ENC];
		bit [31:0] level_since [N_ENC];

		out_beat_t due_events [$];
		int        miss_count;

		function new();
			ccw_keys   = '0;
			cw_keys    = '0;
			btn_keys   = '0;
			step_need  = '0;
			btn_mask   = '0;
			hold_ms    = HOLD_TIME_RST;
			deb_ms     = DEB_TIME_RST;
			miss_count = 0;
			for (int e = 0; e < N_ENC; e++)
				settled_level[e] = 1'b1;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_CCW_KEYS:  ccw_keys  = val;
				REG_CW_KEYS:   cw_keys   = val;
				REG_BTN_KEYS:  btn_keys  = val;
				REG_STEP_THR:  step_need = val;
				REG_BTN_MASK:  btn_mask  = val[7:0];
				REG_HOLD_TIME: hold_ms   = val[15:0];
				REG_DEB_TIME:  deb_ms    = val[15:0];
				default: ;
			endcase
		endfunction

		function void post(logic [7:0] key, logic pressed);
			due_events.push_back('{key_code: key, pressed: pressed, last_of_run: 1'b0});
		endfunction

		// Work out the key events one accepted beat causes.
		function void take_item(in_beat_t b);
			int          first, freed, e, thr, delta;
			logic [15:0] diff;
			logic [31:0] held;
			logic [7:0]  key;
			bit          stepped;
			first = due_events.size();
			if (b.req_type == REQ_TICK) begin
				freed = 0;
				for (int k = 0; k < N_KEYS && freed < MAX_REL; k++)
					if (armed[k] && b.now_ms >= expiry[k]) begin
						post(8'(k), 1'b0);
						armed[k]  = 1'b0;
						expiry[k] = '0;
						freed++;
					end
			end else if (b.encoder_index < N_ENC) begin
				e       = b.encoder_index;
				diff    = b.counter_value - synced_count[e];
				delta   = int'($signed(diff));
				thr     = int'(step_need[e*8 +: 8]);
				stepped = 1'b1;
				key     = '0;
				if (delta >= thr)
					key = cw_keys[e*8 +: 8];
				else if (delta <= -thr)
					key = ccw_keys[e*8 +: 8];
				else
					stepped = 1'b0;
				if (stepped) begin
					post(key, 1'b1);
					expiry[key]     = b.now_ms + 32'(hold_ms);
					armed[key]      = 1'b1;
					synced_count[e] = b.counter_value;
				end
				if (btn_mask[e]) begin
					if (b.button_level != settled_level[e]) begin
						held = b.now_ms - level_since[e];
						if (held >= 32'(deb_ms)) begin
							settled_level[e] = b.button_level;
							post(btn_keys[e*8 +: 8], ~b.button_level);
						end
					end else
						level_since[e] = b.now_ms;
				end
			end
			if (due_events.size() > first)
				due_events[due_events.size() - 1].last_of_run = 1'b1;
		endfunction

		task report_miss(string msg);
			$display("%0t: %s", $time, msg);
			miss_count++;
		endtask

		task match_event(out_beat_t got);
			out_beat_t want;
			if (due_events.size() == 0) begin
				report_miss($sformatf("unexpected beat: key %0d pressed %0b last %0b",
					got.key_code, got.pressed, got.last_of_run));
				return;
			end
			want = due_events.pop_front();
			if (got.key_code !== want.key_code)
				report_miss($sformatf("key_code %0d, want %0d", got.key_code, want.key_code));
			if (got.pressed !== want.pressed)
				report_miss($sformatf("pressed %0b, want %0b (key %0d)",
					got.pressed, want.pressed, want.key_code));
			if (got.last_of_run !== want.last_of_run)
				report_miss($sformatf("last_of_run %0b, want %0b (key %0d)",
					got.last_of_run, want.last_of_run, want.key_code));
		endtask
	endclass

endpackage

// ===== verif/tb_top.sv =====
// Self-checking bench for encoder_key_events: directed cases, then random phases.
`timescale 1ns / 100ps
module tb_top;
	import ekey_pkg::*;
	import ekey_check_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// a full tick walk with every release stalled on the output, plus margin
	localparam int SETTLE_CYCLES = N_KEYS + 2 + MAX_REL * 8 + 32;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 30;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_beat_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_beat_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;

	// when set, that side runs without idle cycles
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	int unsigned cycle_count = 0;

	key_event_tracker tracker;

	encoder_key_events #(
		.ENCODERS (N_ENC),
		.KEYS     (N_KEYS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Hard stop in case the block hangs or drops a beat.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	// Output side: stall a random number of cycles per beat, then take it and check it.
	initial begin : sink
		int stall;
		// hold off until reset is released; outputs are unknown before the first edge
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			tracker.match_event(out_data);
		end
	end

	function automatic in_beat_t tick_at(input logic [31:0] at_ms);
		in_beat_t b;
		// the unused fields carry noise; a tick must ignore them
		b.req_type      = REQ_TICK;
		b.now_ms        = at_ms;
		b.encoder_index = 3'($urandom);
		b.counter_value = 16'($urandom);
		b.button_level  = 1'($urandom);
		return b;
	endfunction

	function automatic in_beat_t sample_of(input int enc, input logic [31:0] at_ms,
			input logic [15:0] count, input logic level);
		in_beat_t b;
		b.req_type      = REQ_SAMPLE;
		b.now_ms        = at_ms;
		b.encoder_index = 3'(enc);
		b.counter_value = count;
		b.button_level  = level;
		return b;
	endfunction

	// Present one beat after a random gap; hold valid and payload until accepted.
	// Valid stays high when the next beat follows with no gap.
	task automatic send(input in_beat_t b);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		tracker.take_item(b);
	endtask

	// Drop valid, wait for every predicted event, then let a silent walk finish.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write enable stays high across back-to-back writes; cfg_done lowers it.
	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
	endtask

	task automatic cfg_done();
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] t;
		logic [15:0] pos [N_ENC];
		logic        want_lvl [N_ENC];
		int          need [N_ENC];
		logic [7:0]  base;
		logic [15:0] hold, deb;
		logic [1:0]  mask_low;
		logic [63:0] map;
		int          pick, e, span, counted;

		tracker = new();
		t = '0;
		for (int i = 0; i < N_ENC; i++) begin
			pos[i]      = '0;
			want_lvl[i] = 1'b1;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- Directed part ---
		// Reset settings: zero thresholds, so an unmoved counter still steps clockwise.
		send(sample_of(0, 32'd0, 16'h0000, 1'b1));
		// Hold time of 15 elapses exactly here.
		send(tick_at(32'd15));
		// Encoder out of range: no events.
		send(sample_of(5, 32'd20, 16'hFFFF, 1'b0));

		drain();
		cfg_write(REG_CCW_KEYS,  64'hF0E1_D2C3_B4A5_2010);
		cfg_write(REG_CW_KEYS,   64'h0F1E_2D3C_4B5A_2111);
		cfg_write(REG_BTN_KEYS,  64'hFFEE_DDCC_BBAA_2212);
		cfg_write(REG_STEP_THR,  64'h5A5A_A5A5_0000_FF04);
		cfg_write(REG_BTN_MASK,  64'h0000_0000_0000_00FF);
		cfg_write(REG_HOLD_TIME, 64'h0000_0000_0000_FFFF);
		cfg_write(REG_DEB_TIME,  64'h0000_0000_0000_0000);
		cfg_write(REG_UNUSED,    {$urandom, $urandom});
		cfg_done();

		// Step exactly at threshold together with a button press (no debounce).
		send(sample_of(0, 32'd100, 16'h0004, 1'b0));
		// Step back counter-clockwise and release the button.
		send(sample_of(0, 32'd101, 16'h0000, 1'b1));
		// Movement below threshold, button unchanged: nothing comes out.
		send(sample_of(1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
		// Half-range jump wraps to the most negative delta.
		send(sample_of(1, 32'hFFFF_FFFF, 16'h8000, 1'b1));
		// Negative again: re-arm the counter-clockwise key.
		send(sample_of(1, 32'h0000_0000, 16'h00FF, 1'b1));
		// Delta of exactly 255 on the largest threshold, plus a button press.
		send(sample_of(1, 32'h0000_0001, 16'h01FE, 1'b0));

		// Arm more keys than one tick may release: new clockwise codes each round.
		drain();
		cfg_write(REG_STEP_THR,  64'h0);
		cfg_write(REG_HOLD_TIME, 64'h0);
		cfg_write(REG_BTN_MASK,  64'h0);
		cfg_done();
		for (int r = 0; r < 7; r++) begin
			drain();
			cfg_write(REG_CW_KEYS, {48'h0, 8'h41 + 8'(2 * r), 8'h40 + 8'(2 * r)});
			cfg_done();
			send(sample_of(0, 32'd200, 16'h0200 + 16'(r), 1'b1));
			send(sample_of(1, 32'd200, 16'h0200 + 16'(r), 1'b1));
		end
		// First tick stops after sixteen releases, the second frees the rest.
		send(tick_at(32'hFFFF_FFFF));
		send(tick_at(32'hFFFF_FFFF));

		// --- Random phases, each with fresh settings ---
		for (int p = 0; p < PHASES; p++) begin
			drain();
			tx_quiet = (p == 2) || (p == 5);
			rx_quiet = (p == 2) || (p == 6);

			// first two phases take the extremes of thresholds and timers
			if (p == 0) begin
				need[0] = 0;
				need[1] = 0;
				hold    = 16'h0000;
				deb     = 16'h0000;
			end else if (p == 1) begin
				need[0] = 255;
				need[1] = 255;
				hold    = 16'hFFFF;
				deb     = 16'hFFFF;
			end else begin
				need[0] = $urandom_range(0, 12);
				need[1] = $urandom_range(0, 12);
				hold    = 16'($urandom_range(1, 40));
				deb     = 16'($urandom_range(0, 10));
			end
			mask_low = (p == 4) ? 2'b01 : 2'b11;

			// keep the six live codes distinct; unused bytes are noise
			base = 8'($urandom);
			map  = {$urandom, $urandom};
			cfg_write(REG_CCW_KEYS, {map[63:16], base + 8'd1, base});
			map  = {$urandom, $urandom};
			cfg_write(REG_CW_KEYS, {map[63:16], base + 8'd3, base + 8'd2});
			map  = {$urandom, $urandom};
			cfg_write(REG_BTN_KEYS, {map[63:16], base + 8'd5, base + 8'd4});
			map  = {$urandom, $urandom};
			cfg_write(REG_STEP_THR, {map[63:16], 8'(need[1]), 8'(need[0])});
			map  = {$urandom, $urandom};
			cfg_write(REG_BTN_MASK, {map[63:2], mask_low});
			map  = {$urandom, $urandom};
			cfg_write(REG_HOLD_TIME, {map[63:16], hold});
			map  = {$urandom, $urandom};
			cfg_write(REG_DEB_TIME, {map[63:16], deb});
			cfg_done();

			// walk time across the 32-bit wrap in one phase
			if (p == 3)
				t = 32'hFFFF_FFC0;

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				t    = t + 32'($urandom_range(0, 6));
				pick = $urandom_range(0, 99);
				if (pick < 18) begin
					send(tick_at(t));
					counted++;
				end else if (pick < 82) begin
					// turn the knob around the threshold; the button level persists
					e      = $urandom_range(0, N_ENC - 1);
					span   = need[e] + 2;
					pos[e] = pos[e] + 16'($urandom_range(0, 2 * span) - span);
					if ($urandom_range(0, 3) == 0)
						want_lvl[e] = ~want_lvl[e];
					send(sample_of(e, t, pos[e], want_lvl[e]));
					counted++;
				end else if (pick < 92) begin
					// counter glitch, bouncing button, sometimes a jump in time
					e = $urandom_range(0, N_ENC - 1);
					if ($urandom_range(0, 1) == 1)
						t = $urandom;
					pos[e] = 16'($urandom);
					send(sample_of(e, t, pos[e], 1'($urandom)));
					counted++;
				end else begin
					send(sample_of($urandom_range(N_ENC, 7), $urandom, 16'($urandom),
						1'($urandom)));
				end
			end
		end

		drain();
		if (tracker.miss_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ekey_pkg.sv
design/ekey_timer_store.sv
design/encoder_key_events.sv
verif/ekey_check_pkg.sv
verif/tb_top.sv
